// File: rtl/core/shp_zrld_pkg.sv
// shared types and constants of the zero-run line decoder
package shp_zrld_pkg;

   localparam int unsigned DEF_MAX_WIDTH  = 1024;
   localparam int unsigned DEF_MAX_HEIGHT = 1024;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned CFG_W     = 11;
   localparam int unsigned RUN_W     = 11;
   localparam int unsigned LEN_W     = 16;
   localparam int unsigned CSR_IDX_W = 2;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COMPRESSED_MODE = 2'd2;

   // shortest line length, the two header bytes alone
   localparam logic [LEN_W-1:0] LEN_MIN = 16'd2;

   localparam int unsigned RSP_QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [BYTE_W-1:0] pixel_value;
      logic [RUN_W-1:0]  run_length;
      logic              line_done;
      logic              frame_done;
      logic              clipped;
      logic              last;
   } rsp_item_type;

endpackage

// File: rtl/core/shp_zrld_rsp_queue.sv
// result queue: takes up to two results per cycle, hands out one per transfer
module shp_zrld_rsp_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [1:0]                 push_cnt,
   input  shp_zrld_pkg::rsp_item_type push0,
   input  shp_zrld_pkg::rsp_item_type push1,
   output logic                       space_two,
   output logic                       out_valid,
   input  logic                       out_ready,
   output shp_zrld_pkg::rsp_item_type out_item
);
   import shp_zrld_pkg::*;

   localparam int unsigned PTR_W = $clog2(RSP_QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(RSP_QUEUE_DEPTH + 1);

   rsp_item_type     q_ff [RSP_QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, wr_next;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   assign out_valid = (count_ff != '0);
   assign out_item  = q_ff[rd_ff];
   assign pop       = out_valid && out_ready;
   assign space_two = (count_ff <= CNT_W'(RSP_QUEUE_DEPTH - 2));

   assign wr_next  = wr_ff + PTR_W'(1);
   assign wr_in    = wr_ff + PTR_W'(push_cnt);
   assign rd_in    = pop ? rd_ff + PTR_W'(1) : rd_ff;
   assign count_in = count_ff + CNT_W'(push_cnt) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         q_ff[wr_ff] <= push0;
      end
      if (push_cnt == 2'd2) begin
         q_ff[wr_next] <= push1;
      end
   end

endmodule

// File: rtl/core/shp_zero_run_line_decoder_unit.sv
// zero-run line decoder: coded sprite bytes in, pixel runs out
// a result can be taken in the cycle after the byte that causes it is accepted
// one byte per cycle while the queue has room for two; a byte that closes a line with a run gives two
//   results, and the result port then sets the pace at one result per cycle
// a four-entry result queue decouples the two sides; bytes are taken while it has room for two
// synchronous reset clears the frame position and queue; config resets to 1 x 1, compressed
module shp_zero_run_line_decoder_unit #(
   parameter int unsigned MAX_WIDTH  = shp_zrld_pkg::DEF_MAX_WIDTH,
   parameter int unsigned MAX_HEIGHT = shp_zrld_pkg::DEF_MAX_HEIGHT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [shp_zrld_pkg::BYTE_W-1:0]     req_tdata,  // data_byte
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [23:0]                         rsp_tdata,  // pixel_value, run_length, zero fill
   output logic [2:0]                          rsp_tuser,  // line_done, frame_done, clipped
   output logic                                rsp_tlast,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [shp_zrld_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [shp_zrld_pkg::CFG_W-1:0]      csr_data
);
   import shp_zrld_pkg::*;

   localparam logic [CFG_W-1:0] WIDTH_CAP  =
      (MAX_WIDTH > 2047) ? 11'd2047 : CFG_W'(MAX_WIDTH);
   localparam logic [CFG_W-1:0] HEIGHT_CAP =
      (MAX_HEIGHT > 2047) ? 11'd2047 : CFG_W'(MAX_HEIGHT);

   typedef enum logic [1:0] {PH_LOW, PH_HIGH, PH_BODY} phase_type;

   // effective (saturated) configuration
   logic [CFG_W-1:0] width_ff, width_in;
   logic [CFG_W-1:0] height_ff, height_in;
   logic             mode_ff, mode_in;

   phase_type        phase_ff, phase_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] used_ff, used_in;
   logic             skip_ff, skip_in;
   logic [CFG_W-1:0] col_ff, col_in;
   logic [CFG_W-1:0] row_ff, row_in;
   logic             clip_ff, clip_in;

   logic             accept, csr_write;
   logic [CFG_W-1:0] room, kept_skip;
   logic             last_row;
   logic [LEN_W-1:0] hdr_len;
   logic             line_end, raw_ld;
   rsp_item_type     res0, res1, line_item;
   logic [1:0]       push_cnt;
   logic             space_two;
   rsp_item_type     out_item;

   assign accept    = req_tvalid && req_tready;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign req_tready = space_two;

   assign room      = (col_ff < width_ff) ? width_ff - col_ff : '0;
   assign kept_skip = ({3'b000, req_tdata} < room) ? {3'b000, req_tdata} : room;
   assign last_row  = ({1'b0, row_ff} + 12'd1) >= {1'b0, height_ff};
   assign hdr_len   = {req_tdata, len_ff[7:0]};

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      mode_in   = mode_ff;
      phase_in  = phase_ff;
      len_in    = len_ff;
      used_in   = used_ff;
      skip_in   = skip_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      clip_in   = clip_ff;
      res0      = '0;
      res1      = '0;
      line_item = '0;
      push_cnt  = 2'd0;
      line_end  = 1'b0;
      raw_ld    = 1'b0;

      if (accept) begin
         if (!mode_ff) begin
            col_in = col_ff + ((room != '0) ? 11'd1 : 11'd0);
            raw_ld = (col_in >= width_ff);
            res0   = '{req_tdata, 11'd1, raw_ld, raw_ld && last_row, clip_ff, 1'b1};
            push_cnt = 2'd1;
            if (raw_ld) begin
               row_in   = last_row ? '0 : row_ff + 11'd1;
               phase_in = PH_LOW;
               len_in   = '0;
               used_in  = '0;
               skip_in  = 1'b0;
               col_in   = '0;
               clip_in  = 1'b0;
            end
         end else begin
            case (phase_ff)
               PH_LOW: begin
                  len_in   = {8'h00, req_tdata};
                  used_in  = 16'd1;
                  phase_in = PH_HIGH;
               end
               PH_HIGH: begin
                  len_in  = (hdr_len < LEN_MIN) ? LEN_MIN : hdr_len;
                  used_in = LEN_MIN;
                  if (hdr_len <= LEN_MIN) begin
                     line_end = 1'b1;
                  end else begin
                     phase_in = PH_BODY;
                  end
               end
               PH_BODY: begin
                  used_in = used_ff + 16'd1;
                  if (skip_ff) begin
                     skip_in = 1'b0;
                     clip_in = clip_ff | ({3'b000, req_tdata} > kept_skip);
                     col_in  = col_ff + kept_skip;
                     if (kept_skip != '0) begin
                        res0     = '{8'h00, kept_skip, 1'b0, 1'b0, clip_in, 1'b1};
                        push_cnt = 2'd1;
                     end
                  end else if (req_tdata != 8'h00) begin
                     if (room != '0) begin
                        col_in   = col_ff + 11'd1;
                        res0     = '{req_tdata, 11'd1, 1'b0, 1'b0, clip_ff, 1'b1};
                        push_cnt = 2'd1;
                     end else begin
                        clip_in = 1'b1;
                     end
                  end else if (used_in < len_ff) begin
                     skip_in = 1'b1;
                  end
                  // a zero as the line's last byte has no count and is dropped
                  line_end = (used_in >= len_ff);
               end
               default: begin
                  phase_in = PH_LOW;
               end
            endcase

            if (line_end) begin
               line_item = '{8'h00, (col_in < width_ff) ? width_ff - col_in : 11'd0,
                             1'b1, last_row, clip_in, 1'b1};
               if (push_cnt != 2'd0) begin
                  res0.last = 1'b0;
                  res1      = line_item;
                  push_cnt  = 2'd2;
               end else begin
                  res0     = line_item;
                  push_cnt = 2'd1;
               end
               row_in   = last_row ? '0 : row_ff + 11'd1;
               phase_in = PH_LOW;
               len_in   = '0;
               used_in  = '0;
               skip_in  = 1'b0;
               col_in   = '0;
               clip_in  = 1'b0;
            end
         end
      end

      // a write to the width, height or mode register restarts the frame
      if (csr_write && (csr_index == CSR_FRAME_WIDTH || csr_index == CSR_FRAME_HEIGHT ||
                        csr_index == CSR_COMPRESSED_MODE)) begin
         case (csr_index)
            CSR_FRAME_WIDTH: begin
               width_in = (csr_data == '0) ? 11'd1 :
                          (csr_data > WIDTH_CAP) ? WIDTH_CAP : csr_data;
            end
            CSR_FRAME_HEIGHT: begin
               height_in = (csr_data == '0) ? 11'd1 :
                           (csr_data > HEIGHT_CAP) ? HEIGHT_CAP : csr_data;
            end
            CSR_COMPRESSED_MODE: begin
               mode_in = csr_data[0];
            end
            default: begin
               mode_in = mode_ff;
            end
         endcase
         phase_in = PH_LOW;
         len_in   = '0;
         used_in  = '0;
         skip_in  = 1'b0;
         col_in   = '0;
         row_in   = '0;
         clip_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 11'd1;
         height_ff <= 11'd1;
         mode_ff   <= 1'b1;
         phase_ff  <= PH_LOW;
         len_ff    <= '0;
         used_ff   <= '0;
         skip_ff   <= 1'b0;
         col_ff    <= '0;
         row_ff    <= '0;
         clip_ff   <= 1'b0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         mode_ff   <= mode_in;
         phase_ff  <= phase_in;
         len_ff    <= len_in;
         used_ff   <= used_in;
         skip_ff   <= skip_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         clip_ff   <= clip_in;
      end
   end

   shp_zrld_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push_cnt  (push_cnt),
      .push0     (res0),
      .push1     (res1),
      .space_two (space_two),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (out_item)
   );

   assign rsp_tdata = {5'b00000, out_item.run_length, out_item.pixel_value};
   assign rsp_tuser = {out_item.clipped, out_item.frame_done, out_item.line_done};
   assign rsp_tlast = out_item.last;

endmodule

// File: tb/shp_zrld_checker.sv
// run predictor and result checker for the zero-run line decoder
module shp_zrld_checker #(
   parameter int unsigned MAX_WIDTH  = shp_zrld_pkg::DEF_MAX_WIDTH,
   parameter int unsigned MAX_HEIGHT = shp_zrld_pkg::DEF_MAX_HEIGHT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [shp_zrld_pkg::BYTE_W-1:0]    req_tdata,  // data_byte
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [23:0]                        rsp_tdata,  // pixel_value, run_length, zero fill
   input  logic [2:0]                         rsp_tuser,  // line_done, frame_done, clipped
   input  logic                               rsp_tlast,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [shp_zrld_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [shp_zrld_pkg::CFG_W-1:0]     csr_data,
   output int unsigned                        fail_count,
   output int unsigned                        runs_pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import shp_zrld_pkg::*;

   typedef enum logic [1:0] {HDR_LOW, HDR_HIGH, HDR_BODY} hdr_phase_type;

   logic [CFG_W-1:0] cfg_width;
   logic [CFG_W-1:0] cfg_height;
   logic             cfg_compressed;

   hdr_phase_type    hdr_phase;
   logic [LEN_W-1:0] line_len;
   logic [LEN_W-1:0] bytes_used;
   logic             skip_armed;
   logic             line_clip;
   int unsigned      col;
   int unsigned      row;

   rsp_item_type runs_due[$];
   rsp_item_type step_runs[2];
   int unsigned  step_count;
   int unsigned  mismatches = 0;
   int unsigned  due_count = 0;

   assign fail_count   = mismatches;
   assign runs_pending = due_count;

   function automatic int unsigned width_eff();
      if (cfg_width == '0) return 1;
      if (cfg_width > MAX_WIDTH) return MAX_WIDTH;
      return cfg_width;
   endfunction

   function automatic int unsigned height_eff();
      if (cfg_height == '0) return 1;
      if (cfg_height > MAX_HEIGHT) return MAX_HEIGHT;
      return cfg_height;
   endfunction

   task automatic start_line();
      hdr_phase  = HDR_LOW;
      line_len   = '0;
      bytes_used = '0;
      skip_armed = 1'b0;
      col        = 0;
      line_clip  = 1'b0;
   endtask

   task automatic add_run(input logic [BYTE_W-1:0] pix, input int unsigned len,
                          input logic ld, input logic fd);
      step_runs[step_count].pixel_value = pix;
      step_runs[step_count].run_length  = RUN_W'(len);
      step_runs[step_count].line_done   = ld;
      step_runs[step_count].frame_done  = fd;
      step_runs[step_count].clipped     = line_clip;
      step_runs[step_count].last        = 1'b0;
      step_count++;
   endtask

   // keeps what fits in the line, marks the line clipped if anything is dropped
   function automatic int unsigned place_pixels(input int unsigned count);
      int unsigned room;
      int unsigned kept;
      room = (col < width_eff()) ? width_eff() - col : 0;
      kept = (count < room) ? count : room;
      if (count > kept) line_clip = 1'b1;
      col += kept;
      return kept;
   endfunction

   task automatic close_line();
      logic fd;
      fd = (row + 1 >= height_eff());
      add_run('0, (col < width_eff()) ? width_eff() - col : 0, 1'b1, fd);
      row = fd ? 0 : row + 1;
      start_line();
   endtask

   task automatic decode_byte(input logic [BYTE_W-1:0] b);
      logic        ld;
      logic        fd;
      logic        at_end;
      int unsigned kept;
      step_count = 0;
      if (!cfg_compressed) begin
         kept = place_pixels(1);
         ld = (col >= width_eff());
         fd = ld && (row + 1 >= height_eff());
         add_run(b, 1, ld, fd);
         if (ld) begin
            row = fd ? 0 : row + 1;
            start_line();
         end
      end else begin
         case (hdr_phase)
            HDR_LOW: begin
               line_len   = {8'h00, b};
               bytes_used = 16'd1;
               hdr_phase  = HDR_HIGH;
            end
            HDR_HIGH: begin
               line_len = {b, line_len[7:0]};
               if (line_len < LEN_MIN) line_len = LEN_MIN;
               bytes_used = 16'd2;
               if (bytes_used >= line_len) close_line();
               else hdr_phase = HDR_BODY;
            end
            default: begin
               bytes_used = bytes_used + 16'd1;
               at_end = (bytes_used >= line_len);
               if (skip_armed) begin
                  skip_armed = 1'b0;
                  kept = place_pixels(b);
                  if (kept > 0) add_run('0, kept, 1'b0, 1'b0);
               end else if (b != '0) begin
                  if (place_pixels(1) > 0) add_run(b, 1, 1'b0, 1'b0);
               end else if (!at_end) begin
                  skip_armed = 1'b1;
               end
               // a zero on the last byte of a line has no count and is dropped
               if (at_end) close_line();
            end
         endcase
      end
      if (step_count > 0) step_runs[step_count-1].last = 1'b1;
      for (int i = 0; i < step_count; i++) runs_due.push_back(step_runs[i]);
   endtask

   always @(posedge clock) begin
      rsp_item_type got;
      rsp_item_type want;
      if (reset) begin
         cfg_width      = 11'd1;
         cfg_height     = 11'd1;
         cfg_compressed = 1'b1;
         start_line();
         row = 0;
         runs_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.pixel_value = rsp_tdata[7:0];
            got.run_length  = rsp_tdata[18:8];
            got.line_done   = rsp_tuser[0];
            got.frame_done  = rsp_tuser[1];
            got.clipped     = rsp_tuser[2];
            got.last        = rsp_tlast;
            if (rsp_tdata[23:19] !== '0) begin
               mismatches++;
               $display("%0t: tdata fill bits expected 0, got %b", $time, rsp_tdata[23:19]);
            end
            if (runs_due.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected run, expected none, got pix %0d len %0d ld %b fd %b clip %b last %b",
                        $time, got.pixel_value, got.run_length, got.line_done,
                        got.frame_done, got.clipped, got.last);
            end else begin
               want = runs_due.pop_front();
               if (got !== want) begin
                  mismatches++;
                  $display("%0t: run mismatch, expected pix %0d len %0d ld %b fd %b clip %b last %b",
                           $time, want.pixel_value, want.run_length, want.line_done,
                           want.frame_done, want.clipped, want.last);
                  $display("%0t:                 got pix %0d len %0d ld %b fd %b clip %b last %b",
                           $time, got.pixel_value, got.run_length, got.line_done,
                           got.frame_done, got.clipped, got.last);
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FRAME_WIDTH: begin
                  cfg_width = csr_data;
                  start_line();
                  row = 0;
               end
               CSR_FRAME_HEIGHT: begin
                  cfg_height = csr_data;
                  start_line();
                  row = 0;
               end
               CSR_COMPRESSED_MODE: begin
                  cfg_compressed = csr_data[0];
                  start_line();
                  row = 0;
               end
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) decode_byte(req_tdata);
      end
      due_count = runs_due.size();
   end

endmodule

// File: tb/tb.sv
// stimulus and verdict for the zero-run line decoder
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import shp_zrld_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;  // no register behind this index
   localparam int unsigned RANDOM_BYTES = 1600;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [BYTE_W-1:0]    req_tdata  = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [23:0]          rsp_tdata;
   logic [2:0]           rsp_tuser;
   logic                 rsp_tlast;
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [CFG_W-1:0]     csr_data   = '0;

   int unsigned fail_count;
   int unsigned runs_pending;
   bit          steady     = 1'b0;
   int unsigned bytes_sent = 0;

   always #4 clock = ~clock;

   shp_zero_run_line_decoder_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   shp_zrld_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .fail_count   (fail_count),
      .runs_pending (runs_pending)
   );

   always @(negedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= 15);
   end

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      while (!steady && $urandom_range(0, 99) < 15) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         req_tdata  <= BYTE_W'($urandom);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // stop sending until every run is out, then let the pipeline settle
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (runs_pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic send_line(input int unsigned skip_top);
      logic [BYTE_W-1:0] body[$];
      int unsigned kind;
      int unsigned n_tok;
      int unsigned len;
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
         // length 0 or 1, taken as an empty line
         send_byte(BYTE_W'($urandom_range(0, 1)));
         send_byte(8'h00);
      end else if (kind == 1) begin
         repeat ($urandom_range(1, 6)) send_byte(BYTE_W'($urandom));
      end else begin
         // now and then a long line, which can pass 255 bytes so the high length byte is used
         n_tok = (kind == 2) ? $urandom_range(200, 260) : $urandom_range(0, 8);
         repeat (n_tok) begin
            if ($urandom_range(0, 3) == 0) begin
               body.push_back(8'h00);
               if ($urandom_range(0, 15) == 0) body.push_back(BYTE_W'($urandom));
               else body.push_back(BYTE_W'($urandom_range(0, skip_top)));
            end else begin
               body.push_back(BYTE_W'($urandom_range(1, 255)));
            end
         end
         if ($urandom_range(0, 3) == 0) body.push_back(8'h00);
         len = body.size() + 2;
         send_byte(len[7:0]);
         send_byte(len[15:8]);
         foreach (body[i]) send_byte(body[i]);
      end
   endtask

   initial begin
      // width 4, two lines per frame: pixels, a skip, a trailing zero, a short length,
      // then an overrun skip, a dropped pixel, a zero skip at line end and a zero length
      static logic [BYTE_W-1:0] coded_frames [18] = '{
         8'h07, 8'h00, 8'hFF, 8'h00, 8'h02, 8'h01, 8'h00,
         8'h01, 8'h00,
         8'h07, 8'h00, 8'h00, 8'h05, 8'h80, 8'h00, 8'h00,
         8'h00, 8'h00};
      logic [CFG_W-1:0] width;
      logic [CFG_W-1:0] height;
      logic             coded;
      int unsigned      w_eff;
      int unsigned      skip_top;
      int unsigned      n_lines;
      int unsigned      phase;
      int unsigned      base;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_reg(CSR_FRAME_WIDTH, 11'd4);
      write_reg(CSR_FRAME_HEIGHT, 11'd2);
      write_reg(CSR_COMPRESSED_MODE, 11'd1);
      foreach (coded_frames[i]) send_byte(coded_frames[i]);
      drain();

      write_reg(CSR_COMPRESSED_MODE, 11'd0);
      write_reg(CSR_FRAME_WIDTH, 11'd3);
      write_reg(CSR_FRAME_HEIGHT, 11'd1);
      send_byte(8'h00);
      drain();
      // write to an unused index must not disturb the line in progress
      write_reg(CSR_SPARE, 11'h7FF);
      send_byte(8'hFF);
      send_byte(8'h55);
      drain();
      write_reg(CSR_FRAME_WIDTH, 11'd0);
      write_reg(CSR_FRAME_HEIGHT, 11'd0);
      send_byte(8'hA5);
      send_byte(8'h5A);
      drain();

      phase = 0;
      base  = bytes_sent;
      while (bytes_sent - base < RANDOM_BYTES) begin
         case ($urandom_range(0, 9))
            0:       width = 11'd1024;
            1:       width = '1;
            2:       width = '0;
            3:       width = 11'd1;
            default: width = CFG_W'($urandom_range(2, 12));
         endcase
         case ($urandom_range(0, 9))
            0:       height = '0;
            1:       height = '1;
            2:       height = 11'd1024;
            default: height = CFG_W'($urandom_range(1, 4));
         endcase
         coded = ($urandom_range(0, 3) != 0);
         drain();
         write_reg(CSR_FRAME_WIDTH, width);
         write_reg(CSR_FRAME_HEIGHT, height);
         write_reg(CSR_COMPRESSED_MODE, CFG_W'(coded));
         // a stretch of several frames with no random gaps in the bytes sent and the result port always ready
         steady = (phase >= 3 && phase < 8);
         if (coded) begin
            w_eff = (width == '0) ? 1 : (width > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : width;
            skip_top = (w_eff + 2 > 255) ? 255 : w_eff + 2;
            n_lines = $urandom_range(3, 14);
            for (int li = 0; li < n_lines; li++) begin
               if (phase % 2 == 1 && li == n_lines / 2) drain();
               send_line(skip_top);
            end
         end else begin
            repeat ($urandom_range(20, 120)) send_byte(BYTE_W'($urandom));
         end
         phase++;
      end

      steady = 1'b0;
      drain();
      if (fail_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
